@@ hw/rtl/iqs_pkg.sv @@
package iqs_pkg;

  // Result field widths
  localparam int CNT_W  = 32;
  localparam int MEAN_W = 24;
  localparam int RMS_W  = 24;
  localparam int CORR_W = 17;
  localparam int STAT_W = 2;

  localparam int OUT_FIELD_W = CNT_W + 2 * MEAN_W + 2 * RMS_W + CORR_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // Report status
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FLAT  = 2'd2;

  // Saturation limits
  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [MEAN_W-1:0] MEAN_MAG = {1'b1, {(MEAN_W-1){1'b0}}};
  localparam logic [MEAN_W-1:0] MEAN_POS = {1'b0, {(MEAN_W-1){1'b1}}};
  localparam logic [RMS_W-1:0]  RMS_MAX  = '1;
  localparam logic [CORR_W-1:0] CORR_MAX = {1'b1, {(CORR_W-1){1'b0}}};

  // Arithmetic unit operations
  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } arith_req_t;

endpackage

@@ hw/rtl/iqs_arith.sv @@
// Bit-serial multiply / restoring divide / digit-by-digit square root.
module iqs_arith #(
  parameter int BW = 192
) (
  input  logic                clk,
  input  logic                rst,
  input  iqs_pkg::arith_req_t req,
  input  logic [BW-1:0]       a,
  input  logic [BW-1:0]       b,
  output logic                busy,
  output logic [BW-1:0]       y,
  output logic [BW-1:0]       r
);
  import iqs_pkg::*;

  localparam int CW = $clog2(BW + 1);

  logic [1:0]    op;
  logic [BW-1:0] x;
  logic [BW-1:0] m;
  logic [BW-1:0] acc;
  logic [BW+1:0] rem;
  logic [CW-1:0] cnt;
  logic [BW:0]   rd;
  logic [BW+1:0] rs;
  logic [BW+1:0] trial;

  always_comb begin
    rd    = {rem[BW-1:0], x[BW-1]};
    rs    = {rem[BW-1:0], x[BW-1:BW-2]};
    trial = {acc, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      op   <= req.op;
      x    <= a;
      m    <= b;
      acc  <= '0;
      rem  <= '0;
      cnt  <= (req.op == OP_SQRT) ? CW'(BW / 2) : CW'(BW);
      busy <= 1'b1;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
        unique case (op)
          OP_MUL: begin
            if (m == '0) begin
              busy <= 1'b0;
            end else begin
              if (m[0]) acc <= acc + x;
              x <= x << 1;
              m <= m >> 1;
            end
          end
          OP_DIV: begin
            x <= x << 1;
            if (rd >= {1'b0, m}) begin
              rem <= {1'b0, rd - {1'b0, m}};
              acc <= {acc[BW-2:0], 1'b1};
            end else begin
              rem <= {1'b0, rd};
              acc <= {acc[BW-2:0], 1'b0};
            end
          end
          OP_SQRT: begin
            x <= x << 2;
            if (rs >= trial) begin
              rem <= rs - trial;
              acc <= {acc[BW-2:0], 1'b1};
            end else begin
              rem <= rs;
              acc <= {acc[BW-2:0], 1'b0};
            end
          end
          default: busy <= 1'b0;
        endcase
      end
    end
  end

  assign y = acc;
  assign r = rem[BW-1:0];

endmodule

@@ hw/rtl/iqs_queue.sv @@
// Two-entry queue between front end and report engine.
module iqs_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   fill;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = mem[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop) rp <= ~rp;
      if (do_push && !do_pop) fill <= fill + 2'd1;
      else if (do_pop && !do_push) fill <= fill - 2'd1;
    end
  end

endmodule

@@ hw/rtl/iqs_front.sv @@
// Per-channel accumulators; a report snapshots one channel into the queue and clears it.
module iqs_front #(
  parameter int COUNT_BITS  = 32,
  parameter int SAMPLE_BITS = 8,
  parameter int CHANNELS    = 2,
  parameter int REC_W       = 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic                          channel,
  input  logic signed [SAMPLE_BITS-1:0] i_sample,
  input  logic signed [SAMPLE_BITS-1:0] q_sample,
  output logic                          push_valid,
  input  logic                          push_ready,
  output logic [REC_W-1:0]              push_data
);

  localparam int SUMW = COUNT_BITS + SAMPLE_BITS;
  localparam int SQW  = COUNT_BITS + 2 * SAMPLE_BITS;

  logic [COUNT_BITS-1:0] cnt [CHANNELS];
  logic [SUMW-1:0]       si  [CHANNELS];
  logic [SUMW-1:0]       sq  [CHANNELS];
  logic [SQW-1:0]        sii [CHANNELS];
  logic [SQW-1:0]        sqq [CHANNELS];
  logic [SQW-1:0]        siq [CHANNELS];

  logic                  in_range;
  logic                  is_rep;
  logic                  accept;
  logic signed [2*SAMPLE_BITS-1:0] pii;
  logic signed [2*SAMPLE_BITS-1:0] pqq;
  logic signed [2*SAMPLE_BITS-1:0] piq;
  logic [COUNT_BITS-1:0] s_cnt;
  logic [SUMW-1:0]       s_si;
  logic [SUMW-1:0]       s_sq;
  logic [SQW-1:0]        s_sii;
  logic [SQW-1:0]        s_sqq;
  logic [SQW-1:0]        s_siq;

  always_comb begin
    in_range = int'(channel) < CHANNELS;
    is_rep   = command && in_range;
    in_ready = !is_rep || push_ready;
    accept   = in_valid && in_ready;
    pii      = i_sample * i_sample;
    pqq      = q_sample * q_sample;
    piq      = i_sample * q_sample;
    s_cnt = '0;
    s_si  = '0;
    s_sq  = '0;
    s_sii = '0;
    s_sqq = '0;
    s_siq = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (int'(channel) == c) begin
        s_cnt = cnt[c];
        s_si  = si[c];
        s_sq  = sq[c];
        s_sii = sii[c];
        s_sqq = sqq[c];
        s_siq = siq[c];
      end
    end
    push_valid = in_valid && is_rep;
    push_data  = {s_siq, s_sqq, s_sii, s_sq, s_si, s_cnt, channel};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        cnt[c] <= '0;
        si[c]  <= '0;
        sq[c]  <= '0;
        sii[c] <= '0;
        sqq[c] <= '0;
        siq[c] <= '0;
      end
    end else if (accept) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (int'(channel) == c) begin
          if (command) begin
            cnt[c] <= '0;
            si[c]  <= '0;
            sq[c]  <= '0;
            sii[c] <= '0;
            sqq[c] <= '0;
            siq[c] <= '0;
          end else if (cnt[c] != '1) begin
            cnt[c] <= cnt[c] + 1'b1;
            si[c]  <= si[c] + SUMW'(i_sample);
            sq[c]  <= sq[c] + SUMW'(q_sample);
            sii[c] <= sii[c] + SQW'(pii);
            sqq[c] <= sqq[c] + SQW'(pqq);
            siq[c] <= siq[c] + SQW'(piq);
          end
        end
      end
    end
  end

endmodule

@@ hw/rtl/iqs_back.sv @@
// Report engine: sequences the arithmetic unit over one snapshot and holds the result.
module iqs_back #(
  parameter int COUNT_BITS  = 32,
  parameter int SAMPLE_BITS = 8,
  parameter int REC_W       = 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  logic [REC_W-1:0]             pop_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         report_channel,
  output logic [iqs_pkg::CNT_W-1:0]    sample_count,
  output logic [iqs_pkg::MEAN_W-1:0]   mean_i,
  output logic [iqs_pkg::RMS_W-1:0]    rms_i,
  output logic [iqs_pkg::MEAN_W-1:0]   mean_q,
  output logic [iqs_pkg::RMS_W-1:0]    rms_q,
  output logic [iqs_pkg::CORR_W-1:0]   correlation,
  output logic [iqs_pkg::STAT_W-1:0]   status
);
  import iqs_pkg::*;

  localparam int SUMW = COUNT_BITS + SAMPLE_BITS;
  localparam int SQW  = COUNT_BITS + 2 * SAMPLE_BITS;
  localparam int BW   = 4 * (COUNT_BITS + SAMPLE_BITS) + 32;
  localparam int O_SI = 1 + COUNT_BITS;
  localparam int O_SQ = O_SI + SUMW;
  localparam int O_II = O_SQ + SUMW;
  localparam int O_QQ = O_II + SQW;
  localparam int O_IQ = O_QQ + SQW;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SI2  = 5'd1;
  localparam logic [4:0] ST_NSII = 5'd2;
  localparam logic [4:0] ST_SQ2  = 5'd3;
  localparam logic [4:0] ST_NSQQ = 5'd4;
  localparam logic [4:0] ST_SISQ = 5'd5;
  localparam logic [4:0] ST_NSIQ = 5'd6;
  localparam logic [4:0] ST_NN   = 5'd7;
  localparam logic [4:0] ST_DMI  = 5'd8;
  localparam logic [4:0] ST_DMQ  = 5'd9;
  localparam logic [4:0] ST_DVI  = 5'd10;
  localparam logic [4:0] ST_RTI  = 5'd11;
  localparam logic [4:0] ST_DVQ  = 5'd12;
  localparam logic [4:0] ST_RTQ  = 5'd13;
  localparam logic [4:0] ST_PROD = 5'd14;
  localparam logic [4:0] ST_RTP  = 5'd15;
  localparam logic [4:0] ST_DCOR = 5'd16;
  localparam logic [4:0] ST_CORR = 5'd17;
  localparam logic [4:0] ST_WAIT = 5'd18;

  logic [4:0]            state;
  logic [4:0]            ret;
  logic [BW-1:0]         n_r, si_r, sq_r, sii_r, sqq_r, siq_r;
  logic [BW-1:0]         t_r, vi_r, vq_r, cv_r, n2_r;
  logic [COUNT_BITS-1:0] rec_cnt;
  logic [SUMW-1:0]       rec_si;
  logic [SUMW-1:0]       rec_sq;
  logic [SQW-1:0]        rec_siq;
  logic [BW-1:0]         diff;
  logic                  flat;
  arith_req_t            req;
  logic [BW-1:0]         opa;
  logic [BW-1:0]         opb;
  logic                  busy;
  logic [BW-1:0]         y;
  logic [BW-1:0]         r;

  function automatic logic [BW-1:0] absw(input logic [BW-1:0] v);
    return v[BW-1] ? ('0 - v) : v;
  endfunction

  function automatic logic [MEAN_W-1:0] mean_fix(input logic neg, input logic [BW-1:0] q,
                                                 input logic [BW-1:0] rm);
    logic [BW-1:0] v;
    v = (q > BW'(MEAN_MAG)) ? BW'(MEAN_MAG) : q;
    if (neg) begin
      if (rm != '0 && v < BW'(MEAN_MAG)) v = v + 1'b1;
      v = '0 - v;
      return v[MEAN_W-1:0];
    end
    return (v > BW'(MEAN_POS)) ? MEAN_POS : v[MEAN_W-1:0];
  endfunction

  function automatic logic [RMS_W-1:0] rms_fix(input logic [BW-1:0] v);
    return (v > BW'(RMS_MAX)) ? RMS_MAX : v[RMS_W-1:0];
  endfunction

  iqs_arith #(.BW(BW)) u_arith (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (opa),
    .b    (opb),
    .busy (busy),
    .y    (y),
    .r    (r)
  );

  always_comb begin
    rec_cnt   = pop_data[1 +: COUNT_BITS];
    rec_si    = pop_data[O_SI +: SUMW];
    rec_sq    = pop_data[O_SQ +: SUMW];
    rec_siq   = pop_data[O_IQ +: SQW];
    pop_ready = (state == ST_IDLE) && !out_valid;
    diff      = y - t_r;
    flat      = (vi_r == '0) || (vq_r == '0);
    req.start = 1'b1;
    req.op    = OP_MUL;
    opa       = '0;
    opb       = '0;
    unique case (state)
      ST_SI2:  begin opa = si_r; opb = si_r;  end
      ST_NSII: begin opa = n_r;  opb = sii_r; end
      ST_SQ2:  begin opa = sq_r; opb = sq_r;  end
      ST_NSQQ: begin opa = n_r;  opb = sqq_r; end
      ST_SISQ: begin opa = si_r; opb = sq_r;  end
      ST_NSIQ: begin opa = n_r;  opb = siq_r; end
      ST_NN:   begin opa = n_r;  opb = n_r;   end
      ST_DMI:  begin req.op = OP_DIV; opa = absw(si_r) << 16; opb = n_r; end
      ST_DMQ:  begin req.op = OP_DIV; opa = absw(sq_r) << 16; opb = n_r; end
      ST_DVI:  begin req.op = OP_DIV; opa = vi_r << 32; opb = n2_r; end
      ST_RTI:  begin req.op = OP_SQRT; opa = y; end
      ST_DVQ:  begin req.op = OP_DIV; opa = vq_r << 32; opb = n2_r; end
      ST_RTQ:  begin req.op = OP_SQRT; opa = y; end
      ST_PROD: begin req.start = !flat; opa = vi_r; opb = vq_r; end
      ST_RTP:  begin req.op = OP_SQRT; opa = y; end
      ST_DCOR: begin req.op = OP_DIV; opa = cv_r << 16; opb = y; end
      default: req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (req.start) state <= ST_WAIT;
      unique case (state)
        ST_IDLE: begin
          if (pop_valid && pop_ready) begin
            report_channel <= pop_data[0];
            sample_count   <= (BW'(rec_cnt) > BW'(CNT_MAX)) ? CNT_MAX : CNT_W'(rec_cnt);
            n_r   <= BW'(rec_cnt);
            si_r  <= {{(BW-SUMW){rec_si[SUMW-1]}}, rec_si};
            sq_r  <= {{(BW-SUMW){rec_sq[SUMW-1]}}, rec_sq};
            sii_r <= BW'(pop_data[O_II +: SQW]);
            sqq_r <= BW'(pop_data[O_QQ +: SQW]);
            siq_r <= {{(BW-SQW){rec_siq[SQW-1]}}, rec_siq};
            if (rec_cnt == '0) begin
              mean_i      <= '0;
              rms_i       <= '0;
              mean_q      <= '0;
              rms_q       <= '0;
              correlation <= '0;
              status      <= STAT_EMPTY;
              out_valid   <= 1'b1;
            end else begin
              state <= ST_SI2;
            end
          end
        end
        ST_SI2:  ret <= ST_NSII;
        ST_NSII: begin t_r <= y; ret <= ST_SQ2; end
        ST_SQ2:  begin vi_r <= diff[BW-1] ? '0 : diff; ret <= ST_NSQQ; end
        ST_NSQQ: begin t_r <= y; ret <= ST_SISQ; end
        ST_SISQ: begin vq_r <= diff[BW-1] ? '0 : diff; ret <= ST_NSIQ; end
        ST_NSIQ: begin t_r <= y; ret <= ST_NN; end
        ST_NN:   begin cv_r <= absw(diff); ret <= ST_DMI; end
        ST_DMI:  begin n2_r <= y; ret <= ST_DMQ; end
        ST_DMQ:  begin mean_i <= mean_fix(si_r[BW-1], y, r); ret <= ST_DVI; end
        ST_DVI:  begin mean_q <= mean_fix(sq_r[BW-1], y, r); ret <= ST_RTI; end
        ST_RTI:  ret <= ST_DVQ;
        ST_DVQ:  begin rms_i <= rms_fix(y); ret <= ST_RTQ; end
        ST_RTQ:  ret <= ST_PROD;
        ST_PROD: begin
          rms_q <= rms_fix(y);
          ret   <= ST_RTP;
          if (flat) begin
            correlation <= '0;
            status      <= STAT_FLAT;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        ST_RTP:  ret <= ST_DCOR;
        ST_DCOR: ret <= ST_CORR;
        ST_CORR: begin
          correlation <= (y > BW'(CORR_MAX)) ? CORR_MAX : y[CORR_W-1:0];
          status      <= STAT_OK;
          out_valid   <= 1'b1;
          state       <= ST_IDLE;
        end
        ST_WAIT: if (!busy) state <= ret;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/iq_sample_statistics_core.sv @@
// I/Q sample statistics. Each input transaction either adds one signed I/Q pair to the
// running sums of a channel (count, sum I, sum Q, sum I^2, sum Q^2, sum I*Q) or asks for a
// report of that channel, which then starts over from zero. Accumulation takes one
// transaction per clock with no stall. A report copies the channel's sums into a two-entry
// queue in the same cycle; a report engine behind the queue works the snapshot out on one
// shared bit-serial multiply/divide/square-root unit of width
// BW = 4*(COUNT_BITS+SAMPLE_BITS)+32 (192 at defaults). A report whose count and deviations
// are all nonzero runs eight multiplies, five divides and three square roots; a flat one
// stops after the second square root, and an empty one runs none. The unit does one bit per
// cycle, a multiply ending early once its multiplier runs out of set bits; samples keep
// flowing meanwhile, and s_tready drops only for a report that finds the queue full. Each
// report returns one output transaction:
// count, means (signed Q8.16, floored), standard deviations (Q8.16), and |correlation|
// (Q1.16, capped at 1.0). Status is 1 with all-zero fields for an empty channel, and 2 with
// zero correlation when either deviation is zero. Samples past a full count are dropped;
// a channel index at or above CHANNELS is ignored without a result.
module iq_sample_statistics_core #(
  parameter int COUNT_BITS  = 32,
  parameter int SAMPLE_BITS = 8,
  parameter int CHANNELS    = 2
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // i_sample, q_sample, zero pad
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
  // command, channel
  input  logic [1:0]                            s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // sample_count, mean_i, rms_i, mean_q, rms_q, correlation, zero pad
  output logic [iqs_pkg::OUT_DATA_W-1:0]        m_tdata,
  // report_channel, status
  output logic [2:0]                            m_tuser
);
  import iqs_pkg::*;

  localparam int SUMW  = COUNT_BITS + SAMPLE_BITS;
  localparam int SQW   = COUNT_BITS + 2 * SAMPLE_BITS;
  localparam int REC_W = 1 + COUNT_BITS + 2 * SUMW + 3 * SQW;

  logic              push_valid;
  logic              push_ready;
  logic [REC_W-1:0]  push_data;
  logic              pop_valid;
  logic              pop_ready;
  logic [REC_W-1:0]  pop_data;
  logic              report_channel;
  logic [CNT_W-1:0]  sample_count;
  logic [MEAN_W-1:0] mean_i;
  logic [RMS_W-1:0]  rms_i;
  logic [MEAN_W-1:0] mean_q;
  logic [RMS_W-1:0]  rms_q;
  logic [CORR_W-1:0] correlation;
  logic [STAT_W-1:0] status;

  // Front end: accumulators, one lane per channel
  iqs_front #(
    .COUNT_BITS  (COUNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CHANNELS    (CHANNELS),
    .REC_W       (REC_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .command    (s_tuser[0]),
    .channel    (s_tuser[1]),
    .i_sample   (s_tdata[SAMPLE_BITS-1:0]),
    .q_sample   (s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Snapshots waiting for the report engine
  iqs_queue #(.W(REC_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Report engine; its result registers double as the output stage
  iqs_back #(
    .COUNT_BITS  (COUNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .REC_W       (REC_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_data       (pop_data),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .report_channel (report_channel),
    .sample_count   (sample_count),
    .mean_i         (mean_i),
    .rms_i          (rms_i),
    .mean_q         (mean_q),
    .rms_q          (rms_q),
    .correlation    (correlation),
    .status         (status)
  );

  assign m_tdata = {{(OUT_DATA_W-OUT_FIELD_W){1'b0}}, correlation, rms_q, mean_q, rms_i,
                    mean_i, sample_count};
  assign m_tuser = {status, report_channel};

endmodule
